@@ src/kcpc_pkg.sv @@
// Package: shared types, codes and constants of the key combination press classifier.
`timescale 1ns / 1ps

package kcpc_pkg;

    localparam int COUNTER_BITS = 12;
    localparam int LIMIT_W      = 12;
    localparam int CMP_W        = (COUNTER_BITS > LIMIT_W) ? COUNTER_BITS : LIMIT_W;
    localparam int NUM_COMBOS   = 7;
    localparam int DATA_W       = 12;
    localparam int IDX_W        = 3;

    typedef logic [COUNTER_BITS-1:0] cnt_t;
    typedef logic [LIMIT_W-1:0]      limit_t;
    typedef logic [2:0]              combo_t;

    typedef enum logic [1:0] {
        FLAG_NONE  = 2'd0,
        FLAG_SHORT = 2'd1,
        FLAG_LONG  = 2'd2
    } flag_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } held_evt_t;

    typedef enum logic [2:0] {
        REL_NONE  = 3'd0,
        REL_POWER = 3'd1,
        REL_NET   = 3'd2,
        REL_MODE  = 3'd3,
        REL_ALL   = 3'd4
    } rel_t;

    localparam combo_t COMBO_POWER      = 3'd0;
    localparam combo_t COMBO_NET        = 3'd1;
    localparam combo_t COMBO_MODE       = 3'd2;
    localparam combo_t COMBO_ALL        = 3'd3;
    localparam combo_t COMBO_NET_MODE   = 3'd4;
    localparam combo_t COMBO_POWER_MODE = 3'd5;
    localparam combo_t COMBO_POWER_NET  = 3'd6;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE      = 3'd0,
        REG_LONG_POWER    = 3'd1,
        REG_LONG_NET_MODE = 3'd2,
        REG_LONG_OTHER    = 3'd3,
        REG_CLICK_WINDOW  = 3'd4,
        REG_CLICK_TARGET  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic      multi_click;
        rel_t      release_short;
        combo_t    held_combo;
        held_evt_t held_event;
        logic [2:0] key_mask;
    } result_t;

    function automatic combo_t combo_of_mask(input logic [2:0] mask);
        combo_t c;
        case (mask)
            3'b001:  c = COMBO_POWER;
            3'b010:  c = COMBO_NET;
            3'b011:  c = COMBO_POWER_NET;
            3'b100:  c = COMBO_MODE;
            3'b101:  c = COMBO_POWER_MODE;
            3'b110:  c = COMBO_NET_MODE;
            3'b111:  c = COMBO_ALL;
            default: c = COMBO_POWER;
        endcase
        return c;
    endfunction

endpackage

@@ src/key_combo_press_classifier_core.sv @@
// Top level: key combination short/long press classifier with click counting.
//
//  channel   dir  fields (lowest bit up)
//  s_axis    in   tdata[7:0]: power_level, net_level, mode_level, zero pad
//  m_axis    out  tdata[15:0]: key_mask[2:0], held_event[4:3], held_combo[7:5],
//                 release_short[10:8], multi_click[11], zero pad
//  cfg       in   cfg_wr_en, cfg_addr (register index), cfg_wdata[11:0]
//
// One item per cycle unless m_axis_tready holds the output: an input register,
// one pass of counter/flag update logic, and an output register; tvalid rises
// once the item moves from the input into the output register. While a result
// waits for m_axis_tready, a new item is taken only into an empty input register.
// rst_n clears all counters, flags, click state and restores register defaults.
`timescale 1ns / 1ps

module key_combo_press_classifier_core
    import kcpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // power_level, net_level, mode_level
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // key_mask, held_event, held_combo,
                                              // release_short, multi_click
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_addr,
    input  logic [DATA_W-1:0] cfg_wdata
);

    logic [7:0]   debounce_reg;
    limit_t       long_power_reg;
    limit_t       long_net_mode_reg;
    limit_t       long_other_reg;
    logic [7:0]   click_window_reg;
    logic [3:0]   click_target_reg;

    logic         in_valid_reg;
    logic [2:0]   in_data_reg;
    logic         out_valid_reg;
    result_t      out_data_reg;

    cnt_t         hold_cnt_reg  [NUM_COMBOS];
    cnt_t         hold_cnt_next [NUM_COMBOS];
    flag_t        flag_reg      [NUM_COMBOS];
    flag_t        flag_next     [NUM_COMBOS];
    logic [7:0]   click_timer_reg;
    logic [7:0]   click_timer_next;
    logic [3:0]   click_count_reg;
    logic [3:0]   click_count_next;

    logic         advance;
    logic [2:0]   mask;
    combo_t       combo;
    cnt_t         cnt_sel;
    limit_t       limit_sel;
    logic [3:0]   count_inc;
    result_t      result;
    logic         any_flag;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= 8'd4;
            long_power_reg    <= limit_t'(299);
            long_net_mode_reg <= limit_t'(400);
            long_other_reg    <= limit_t'(200);
            click_window_reg  <= 8'd50;
            click_target_reg  <= 4'd4;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE:      debounce_reg      <= cfg_wdata[7:0];
                REG_LONG_POWER:    long_power_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_LONG_NET_MODE: long_net_mode_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_LONG_OTHER:    long_other_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_CLICK_WINDOW:  click_window_reg  <= cfg_wdata[7:0];
                REG_CLICK_TARGET:  click_target_reg  <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[2:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COMBOS; i++)
            begin
                hold_cnt_reg[i] <= '0;
                flag_reg[i]     <= FLAG_NONE;
            end
            click_timer_reg <= '0;
            click_count_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_COMBOS; i++)
            begin
                hold_cnt_reg[i] <= hold_cnt_next[i];
                flag_reg[i]     <= flag_next[i];
            end
            click_timer_reg <= click_timer_next;
            click_count_reg <= click_count_next;
        end
    end

    always_comb
    begin
        mask      = {~in_data_reg[2], ~in_data_reg[1], in_data_reg[0]};
        combo     = combo_of_mask(mask);
        cnt_sel   = hold_cnt_reg[combo];
        count_inc = '0;
        case (combo)
            COMBO_POWER:    limit_sel = long_power_reg;
            COMBO_NET_MODE: limit_sel = long_net_mode_reg;
            default:        limit_sel = long_other_reg;
        endcase

        result               = '0;
        result.key_mask      = mask;
        result.held_event    = EVT_NONE;
        result.release_short = REL_NONE;

        for (int i = 0; i < NUM_COMBOS; i++)
        begin
            hold_cnt_next[i] = hold_cnt_reg[i];
            flag_next[i]     = flag_reg[i];
        end

        // Timer runs down on each item that advances; an expired window drops the click count.
        if (click_timer_reg != 8'd0)
        begin
            click_timer_next = click_timer_reg - 8'd1;
            click_count_next = click_count_reg;
        end
        else
        begin
            click_timer_next = '0;
            click_count_next = '0;
        end

        if (mask == 3'b000)
        begin
            if (flag_reg[COMBO_POWER_NET] != FLAG_NONE)
            begin
                result.release_short = REL_NONE;
            end
            else if (flag_reg[COMBO_POWER] == FLAG_SHORT)
            begin
                result.release_short = REL_POWER;
                if (click_timer_next != 8'd0)
                begin
                    count_inc = click_count_next + 4'd1;
                    if (count_inc >= click_target_reg)
                    begin
                        click_count_next   = '0;
                        result.multi_click = 1'b1;
                    end
                    else
                    begin
                        click_count_next = count_inc;
                    end
                end
                click_timer_next = click_window_reg;
            end
            else if (flag_reg[COMBO_NET] == FLAG_SHORT)
            begin
                result.release_short = REL_NET;
            end
            else if (flag_reg[COMBO_MODE] == FLAG_SHORT)
            begin
                result.release_short = REL_MODE;
            end
            else if (flag_reg[COMBO_ALL] == FLAG_SHORT)
            begin
                result.release_short = REL_ALL;
            end
            for (int i = 0; i < NUM_COMBOS; i++)
            begin
                hold_cnt_next[i] = '0;
                flag_next[i]     = FLAG_NONE;
            end
        end
        else
        begin
            result.held_combo = combo;
            if (flag_reg[combo] != FLAG_LONG)
            begin
                if (cnt_sel != {COUNTER_BITS{1'b1}})
                begin
                    cnt_sel = cnt_sel + cnt_t'(1);
                    if (CMP_W'(cnt_sel) == CMP_W'(debounce_reg))
                    begin
                        flag_next[combo]  = FLAG_SHORT;
                        result.held_event = EVT_SHORT;
                    end
                end
                if (CMP_W'(cnt_sel) > CMP_W'(limit_sel))
                begin
                    flag_next[combo]  = FLAG_LONG;
                    result.held_event = EVT_LONG;
                end
                hold_cnt_next[combo] = cnt_sel;
            end
        end
    end

    always_comb
    begin
        any_flag = 1'b0;
        for (int i = 0; i < NUM_COMBOS; i++)
        begin
            any_flag = any_flag || (flag_reg[i] != FLAG_NONE);
        end
    end

    a_multi_on_power_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.multi_click) |->
            (out_data_reg.release_short == REL_POWER))
        else $error("multi-click reported without a power release");

    a_hold_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.held_event != EVT_NONE)) |->
            (out_data_reg.release_short == REL_NONE && out_data_reg.key_mask != 3'b000))
        else $error("held event and release reported together");

    a_release_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg == 3'b110) |=> !any_flag)
        else $error("flags not cleared after release");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while output side can move");

endmodule
